>>> hdl/coc_pkg.sv
package coc_pkg;

  // Default sizes
  localparam int CursorMaxWDef     = 64;
  localparam int CursorMaxHDef     = 64;
  localparam int MaxFrameWidthDef  = 4096;
  localparam int MaxFrameHeightDef = 4096;

  // Field widths fixed by the interface
  localparam int PosW     = 13;
  localparam int SizeW    = 7;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;
  localparam int ChanW    = 8;
  localparam int AddrInW  = 12;
  localparam int WordW    = 32;

  // Reset value of the frame width register
  localparam logic [CfgDataW-1:0] FrameWidthRst = 13'd1920;

  // Results the block may hold between input and output
  localparam int OutQDepth = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCursorLeft    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCursorTop     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCursorWidth   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCursorHeight  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCursorMode    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCursorVisible = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFrameWidth    = 3'd6;

  // Request kinds
  localparam logic ActPixel = 1'b0;
  localparam logic ActShape = 1'b1;

  // Cursor modes
  localparam logic ModeAlpha = 1'b0;
  localparam logic ModeXor   = 1'b1;

  localparam logic [ChanW-1:0] AlphaOpaque = 8'd255;

  // One composited pixel
  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] alpha;
    logic             under;
  } out_pix_t;

  localparam int OutPixW = 4 * ChanW + 1;

  // Exact floor(n / 255) for n up to 255 * 255
  function automatic logic [ChanW-1:0] div255(input logic [2*ChanW-1:0] n);
    logic [2*ChanW:0] t;
    t = {1'b0, n} + {9'd0, n[2*ChanW-1:ChanW]} + 17'd1;
    return t[2*ChanW-1:ChanW];
  endfunction

endpackage

>>> hdl/coc_ram.sv
module coc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/coc_fifo.sv
module coc_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

>>> hdl/cursor_overlay_compositor_top.sv
// Cursor overlay compositor.
// Input channel (in_valid_i / in_stall_o) carries two kinds of request: a
// frame pixel (action 0) or a cursor shape word (action 1) that is written
// into the cursor memory at shape_addr and gives no result. Each pixel gives
// exactly one result on the output channel (out_valid_o / out_stall_i), in
// order: blended or XORed with the cursor when it lies in the visible cursor
// window, passed through otherwise.
// Throughput is one request per cycle while in_stall_o is low. A pixel passes
// stage 1 (cursor memory read as it is taken), stage 2 (channel multiplies
// registered) and the divide by 255 into the output queue, in that order.
// Up to four pixel results may be outstanding; in_stall_o rises when that
// many are held, so a stalled receiver backs up the input after four pixels.
// Configuration writes (cfg_we_i) take effect at once; the user must make
// them while idle, and the block does not enforce it. Reset clears the
// position counters, the registers (frame width to 1920) and the pipeline;
// the cursor memory holds no reset value and needs no sweep.
module cursor_overlay_compositor_top #(
  parameter int CURSOR_MAX_W     = coc_pkg::CursorMaxWDef,
  parameter int CURSOR_MAX_H     = coc_pkg::CursorMaxHDef,
  parameter int MAX_FRAME_WIDTH  = coc_pkg::MaxFrameWidthDef,
  parameter int MAX_FRAME_HEIGHT = coc_pkg::MaxFrameHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [coc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [coc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic                          start_of_frame_i,
  input  logic [7:0]                    in_blue_i,
  input  logic [7:0]                    in_green_i,
  input  logic [7:0]                    in_red_i,
  input  logic [7:0]                    in_alpha_i,
  input  logic [coc_pkg::AddrInW-1:0]   shape_addr_i,
  input  logic [coc_pkg::WordW-1:0]     shape_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_blue_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_red_o,
  output logic [7:0]                    out_alpha_o,
  output logic                          under_cursor_o
);
  import coc_pkg::*;

  localparam int Depth = CURSOR_MAX_W * CURSOR_MAX_H;
  localparam int AW    = $clog2(Depth);
  localparam int SAW   = (AW > AddrInW) ? AW : AddrInW;
  localparam int CW    = $clog2(MAX_FRAME_WIDTH);
  localparam int RW    = $clog2(MAX_FRAME_HEIGHT);
  localparam int XW    = $clog2(CURSOR_MAX_W);
  localparam int YW    = $clog2(CURSOR_MAX_H);
  localparam int MW    = (CW > RW) ? CW : RW;
  localparam int DW    = ((MW > PosW) ? MW : PosW) + 2;
  localparam int OCW   = $clog2(OutQDepth + 1);

  // Configuration registers
  logic signed [PosW-1:0]     cursor_left_q;
  logic signed [PosW-1:0]     cursor_top_q;
  logic [SizeW-1:0]           cursor_width_q;
  logic [SizeW-1:0]           cursor_height_q;
  logic                       cursor_mode_q;
  logic                       cursor_visible_q;
  logic [CfgDataW-1:0]        frame_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_left_q    <= '0;
      cursor_top_q     <= '0;
      cursor_width_q   <= '0;
      cursor_height_q  <= '0;
      cursor_mode_q    <= ModeAlpha;
      cursor_visible_q <= 1'b0;
      frame_width_q    <= FrameWidthRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegCursorLeft:    cursor_left_q    <= cfg_data_i;
        RegCursorTop:     cursor_top_q     <= cfg_data_i;
        RegCursorWidth:   cursor_width_q   <= cfg_data_i[SizeW-1:0];
        RegCursorHeight:  cursor_height_q  <= cfg_data_i[SizeW-1:0];
        RegCursorMode:    cursor_mode_q    <= cfg_data_i[0];
        RegCursorVisible: cursor_visible_q <= cfg_data_i[0];
        RegFrameWidth:    frame_width_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request acceptance and outstanding result count
  logic           in_acc;
  logic           pix_acc;
  logic           shape_acc;
  logic           out_pop;
  logic [OCW-1:0] outst_q, outst_d;

  assign in_stall_o = (outst_q == OCW'(OutQDepth));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pix_acc    = in_acc && (action_i == ActPixel);
  assign shape_acc  = in_acc && (action_i == ActShape);
  assign out_pop    = out_valid_o && !out_stall_i;

  always_comb begin
    outst_d = outst_q;
    if (pix_acc && !out_pop) begin
      outst_d = outst_q + OCW'(1);
    end else if (!pix_acc && out_pop) begin
      outst_d = outst_q - OCW'(1);
    end
  end

  // Pixel position
  logic [CW-1:0] col_q, col_d, col_cur;
  logic [RW-1:0] row_q, row_d, row_cur;
  logic [DW-1:0] fw_ext, fw_sat, col_inc, row_inc;

  assign col_cur = start_of_frame_i ? '0 : col_q;
  assign row_cur = start_of_frame_i ? '0 : row_q;

  always_comb begin
    fw_ext  = DW'(frame_width_q);
    fw_sat  = fw_ext;
    if (fw_ext == '0) begin
      fw_sat = DW'(1);
    end else if (fw_ext > DW'(MAX_FRAME_WIDTH)) begin
      fw_sat = DW'(MAX_FRAME_WIDTH);
    end
    col_inc = DW'(col_cur) + DW'(1);
    row_inc = DW'(row_cur) + DW'(1);
    col_d   = col_inc[CW-1:0];
    row_d   = row_cur;
    if (col_inc >= fw_sat) begin
      col_d = '0;
      row_d = (row_inc >= DW'(MAX_FRAME_HEIGHT)) ? '0 : row_inc[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
      if (pix_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // Cursor window test and memory address
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        w_ext, h_ext, w_sat, h_sat;
  logic                 in_win;
  logic [AW-1:0]        rd_addr;

  always_comb begin
    dx    = $signed(DW'(col_cur)) - $signed({{(DW-PosW){cursor_left_q[PosW-1]}},
                                             cursor_left_q});
    dy    = $signed(DW'(row_cur)) - $signed({{(DW-PosW){cursor_top_q[PosW-1]}},
                                             cursor_top_q});
    w_ext = DW'(cursor_width_q);
    h_ext = DW'(cursor_height_q);
    w_sat = (w_ext > DW'(CURSOR_MAX_W)) ? DW'(CURSOR_MAX_W) : w_ext;
    h_sat = (h_ext > DW'(CURSOR_MAX_H)) ? DW'(CURSOR_MAX_H) : h_ext;
    in_win = cursor_visible_q && !dx[DW-1] && !dy[DW-1] &&
             (DW'(dx) < w_sat) && (DW'(dy) < h_sat);
    rd_addr = AW'(dy[YW-1:0]) * AW'(CURSOR_MAX_W) + AW'(dx[XW-1:0]);
  end

  // Shape writes beyond the memory are dropped
  logic [SAW-1:0] wr_addr_ext;
  logic           wr_in_range;

  assign wr_addr_ext = SAW'(shape_addr_i);
  assign wr_in_range = ({1'b0, wr_addr_ext} < (SAW + 1)'(Depth));

  logic [WordW-1:0] rd_word;

  coc_ram #(
    .WIDTH (WordW),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (shape_acc && wr_in_range),
    .waddr_i (wr_addr_ext[AW-1:0]),
    .wdata_i (shape_word_i),
    .re_i    (pix_acc && in_win),
    .raddr_i (rd_addr),
    .rdata_o (rd_word)
  );

  // Stage 1: pixel waits for the cursor word
  logic             s1_vld_q;
  logic             s1_under_q;
  logic [ChanW-1:0] s1_b_q, s1_g_q, s1_r_q, s1_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= pix_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_under_q <= in_win;
      s1_b_q     <= in_blue_i;
      s1_g_q     <= in_green_i;
      s1_r_q     <= in_red_i;
      s1_a_q     <= in_alpha_i;
    end
  end

  // Stage 2: blend numerators or XOR colour
  logic [ChanW-1:0]   sb, sg, sr, sa, inv_a;
  logic [2*ChanW-1:0] val_b, val_g, val_r;
  logic               s2_vld_q;
  logic               s2_under_q;
  logic               s2_blend_q;
  logic [ChanW-1:0]   s2_a_q;
  logic [2*ChanW-1:0] s2_b_q, s2_g_q, s2_r_q;

  always_comb begin
    sb    = rd_word[7:0];
    sg    = rd_word[15:8];
    sr    = rd_word[23:16];
    sa    = rd_word[31:24];
    inv_a = AlphaOpaque - sa;
    val_b = {8'd0, s1_b_q};
    val_g = {8'd0, s1_g_q};
    val_r = {8'd0, s1_r_q};
    if (s1_under_q) begin
      if (cursor_mode_q == ModeXor) begin
        val_b = {8'd0, s1_b_q ^ sb};
        val_g = {8'd0, s1_g_q ^ sg};
        val_r = {8'd0, s1_r_q ^ sr};
      end else begin
        val_b = sb * sa + s1_b_q * inv_a;
        val_g = sg * sa + s1_g_q * inv_a;
        val_r = sr * sa + s1_r_q * inv_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_under_q <= s1_under_q;
      s2_blend_q <= s1_under_q && (cursor_mode_q == ModeAlpha);
      s2_a_q     <= s1_under_q ? AlphaOpaque : s1_a_q;
      s2_b_q     <= val_b;
      s2_g_q     <= val_g;
      s2_r_q     <= val_r;
    end
  end

  // Stage 3: divide by 255 into the output queue
  out_pix_t s2_pix, q_pix;
  logic [OutPixW-1:0] q_data;

  always_comb begin
    s2_pix.blue  = s2_blend_q ? div255(s2_b_q) : s2_b_q[ChanW-1:0];
    s2_pix.green = s2_blend_q ? div255(s2_g_q) : s2_g_q[ChanW-1:0];
    s2_pix.red   = s2_blend_q ? div255(s2_r_q) : s2_r_q[ChanW-1:0];
    s2_pix.alpha = s2_a_q;
    s2_pix.under = s2_under_q;
  end

  coc_fifo #(
    .WIDTH (OutPixW),
    .DEPTH (OutQDepth)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_vld_q),
    .push_data_i (s2_pix),
    .pop_i       (out_pop),
    .valid_o     (out_valid_o),
    .data_o      (q_data)
  );

  assign q_pix          = q_data;
  assign out_blue_o     = q_pix.blue;
  assign out_green_o    = q_pix.green;
  assign out_red_o      = q_pix.red;
  assign out_alpha_o    = q_pix.alpha;
  assign under_cursor_o = q_pix.under;

endmodule

>>> hdl/coc_checker.sv
module coc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          action_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [7:0]                    out_blue_o,
  input logic [7:0]                    out_green_o,
  input logic [7:0]                    out_red_o,
  input logic [7:0]                    out_alpha_o,
  input logic                          under_cursor_o
);
  import coc_pkg::*;

  localparam int PW = $clog2(OutQDepth + 2);

  logic          pix_acc, out_acc;
  logic [PW-1:0] pend_q;

  assign pix_acc = in_valid_i && !in_stall_o && (action_i == ActPixel);
  assign out_acc = out_valid_o && !out_stall_i;

  // Track pixels taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (pix_acc && !out_acc) begin
      pend_q <= pend_q + PW'(1);
    end else if (!pix_acc && out_acc) begin
      pend_q <= pend_q - PW'(1);
    end
  end

  // No result without a pixel waiting for it
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != '0))
    else $error("result without pending pixel");

  // Pending pixels stay within the output queue
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PW'(OutQDepth))
    else $error("more pixels pending than the queue holds");

  // A cursor pixel is always opaque
  a_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && under_cursor_o) |-> (out_alpha_o == AlphaOpaque))
    else $error("cursor pixel not opaque");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_blue_o) && $stable(out_green_o) &&
       $stable(out_red_o) && $stable(out_alpha_o) && $stable(under_cursor_o)))
    else $error("stalled result changed");

endmodule

bind cursor_overlay_compositor_top coc_checker u_coc_checker (.*);

>>> verif/cursor_overlay_compositor_top_tb.sv
module cursor_overlay_compositor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import coc_pkg::*;

  localparam int CurW       = CursorMaxWDef;
  localparam int CurH       = CursorMaxHDef;
  localparam int StoreDepth = CurW * CurH;
  localparam int MaxFw      = MaxFrameWidthDef;
  localparam int SettleCyc  = 8;
  localparam int HangLimit  = 2000;
  localparam int RandItems  = 600;
  localparam int LongLine   = 64;

  // One request on the input channel
  typedef struct packed {
    logic               act;
    logic               sof;
    logic [ChanW-1:0]   blue;
    logic [ChanW-1:0]   green;
    logic [ChanW-1:0]   red;
    logic [ChanW-1:0]   alpha;
    logic [AddrInW-1:0] addr;
    logic [WordW-1:0]   word;
  } overlay_req_t;

  // One row of the directed table: a register write or a request
  typedef struct packed {
    logic                is_reg;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_val;
    overlay_req_t        rq;
    logic                typed;
    out_pix_t            res;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                action_i = 1'b0;
  logic                start_of_frame_i = 1'b0;
  logic [7:0]          in_blue_i = '0;
  logic [7:0]          in_green_i = '0;
  logic [7:0]          in_red_i = '0;
  logic [7:0]          in_alpha_i = '0;
  logic [AddrInW-1:0]  shape_addr_i = '0;
  logic [WordW-1:0]    shape_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          out_blue_o;
  logic [7:0]          out_green_o;
  logic [7:0]          out_red_o;
  logic [7:0]          out_alpha_o;
  logic                under_cursor_o;

  cursor_overlay_compositor_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .start_of_frame_i (start_of_frame_i),
    .in_blue_i        (in_blue_i),
    .in_green_i       (in_green_i),
    .in_red_i         (in_red_i),
    .in_alpha_i       (in_alpha_i),
    .shape_addr_i     (shape_addr_i),
    .shape_word_i     (shape_word_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_blue_o       (out_blue_o),
    .out_green_o      (out_green_o),
    .out_red_o        (out_red_o),
    .out_alpha_o      (out_alpha_o),
    .under_cursor_o   (under_cursor_o)
  );

  // Shadow of the block: cursor store, position counters, registers
  logic [WordW-1:0]    shape_mem [StoreDepth];
  bit                  shape_written [StoreDepth];
  logic [11:0]         col_pos = '0;
  logic [11:0]         row_pos = '0;
  logic signed [12:0]  cur_left = '0;
  logic signed [12:0]  cur_top = '0;
  logic [SizeW-1:0]    cur_w = '0;
  logic [SizeW-1:0]    cur_h = '0;
  logic                cur_mode = ModeAlpha;
  logic                cur_vis = 1'b0;
  logic [CfgDataW-1:0] frm_w = FrameWidthRst;

  out_pix_t     pending_pixels [$];
  plan_row_t    plan [$];
  int           mismatch_count = 0;
  int           idle_cycles = 0;
  int           stall_run = 0;
  bit           quiet = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Channel value with the extremes weighted up
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    return {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
  endfunction

  function automatic overlay_req_t pixel_req(input logic sof,
                                             input logic [7:0] b, g, r, a);
    overlay_req_t rq;
    rq.act   = ActPixel;
    rq.sof   = sof;
    rq.blue  = b;
    rq.green = g;
    rq.red   = r;
    rq.alpha = a;
    rq.addr  = 12'($urandom);
    rq.word  = $urandom;
    return rq;
  endfunction

  function automatic overlay_req_t shape_req(input logic [AddrInW-1:0] addr,
                                             input logic [WordW-1:0] word);
    overlay_req_t rq;
    rq       = pixel_req(1'($urandom), rand_chan(), rand_chan(), rand_chan(), rand_chan());
    rq.act   = ActShape;
    rq.addr  = addr;
    rq.word  = word;
    return rq;
  endfunction

  function automatic plan_row_t pix_row(input logic sof, input logic [7:0] b, g, r, a);
    plan_row_t row;
    row    = '0;
    row.rq = pixel_req(sof, b, g, r, a);
    return row;
  endfunction

  function automatic plan_row_t pix_typed(input logic sof, input logic [7:0] b, g, r, a,
                                          input logic [7:0] eb, eg, er, ea,
                                          input logic eu);
    plan_row_t row;
    row       = pix_row(sof, b, g, r, a);
    row.typed = 1'b1;
    row.res   = {eb, eg, er, ea, eu};
    return row;
  endfunction

  function automatic plan_row_t shape_row(input logic [AddrInW-1:0] addr,
                                          input logic [WordW-1:0] word);
    plan_row_t row;
    row    = '0;
    row.rq = shape_req(addr, word);
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] val);
    plan_row_t row;
    row         = '0;
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Shadow register write
  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    case (idx)
      RegCursorLeft:    cur_left = val;
      RegCursorTop:     cur_top  = val;
      RegCursorWidth:   cur_w    = val[SizeW-1:0];
      RegCursorHeight:  cur_h    = val[SizeW-1:0];
      RegCursorMode:    cur_mode = val[0];
      RegCursorVisible: cur_vis  = val[0];
      RegFrameWidth:    frm_w    = val;
      default: ;
    endcase
  endfunction

  // Exact straight alpha blend of one channel
  function automatic logic [7:0] mix_channel(input logic [7:0] src, a, dst);
    int num;
    num = int'(src) * int'(a) + int'(dst) * (255 - int'(a));
    return 8'(num / 255);
  endfunction

  // Predict the composited pixel and advance the raster position
  function automatic out_pix_t composite_pixel(input overlay_req_t rq);
    out_pix_t    res;
    int          dx, dy, w_eff, h_eff, fw_eff;
    logic [31:0] sw;
    logic [12:0] col_next;
    res = {rq.blue, rq.green, rq.red, rq.alpha, 1'b0};
    if (rq.sof) begin
      col_pos = '0;
      row_pos = '0;
    end
    w_eff = (int'(cur_w) > CurW) ? CurW : int'(cur_w);
    h_eff = (int'(cur_h) > CurH) ? CurH : int'(cur_h);
    dx = int'(col_pos) - int'(cur_left);
    dy = int'(row_pos) - int'(cur_top);
    if (cur_vis && dx >= 0 && dy >= 0 && dx < w_eff && dy < h_eff) begin
      sw = shape_mem[dy * CurW + dx];
      if (cur_mode == ModeAlpha) begin
        res.blue  = mix_channel(sw[7:0], sw[31:24], rq.blue);
        res.green = mix_channel(sw[15:8], sw[31:24], rq.green);
        res.red   = mix_channel(sw[23:16], sw[31:24], rq.red);
      end else begin
        res.blue  = rq.blue ^ sw[7:0];
        res.green = rq.green ^ sw[15:8];
        res.red   = rq.red ^ sw[23:16];
      end
      res.alpha = AlphaOpaque;
      res.under = 1'b1;
    end
    // A zero width acts as one, an oversized one saturates
    fw_eff = (frm_w == '0) ? 1 : ((int'(frm_w) > MaxFw) ? MaxFw : int'(frm_w));
    col_next = {1'b0, col_pos} + 13'd1;
    if (int'(col_next) >= fw_eff) begin
      col_pos = '0;
      row_pos = row_pos + 12'd1; // wraps with the 12-bit counter
    end else begin
      col_pos = col_next[11:0];
    end
    return res;
  endfunction

  // Drive one request, hold it until taken, then update the shadow
  task automatic push_request(input overlay_req_t rq, input logic typed,
                              input out_pix_t typed_res);
    int       gap;
    out_pix_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= rq.act;
    start_of_frame_i <= rq.sof;
    in_blue_i        <= rq.blue;
    in_green_i       <= rq.green;
    in_red_i         <= rq.red;
    in_alpha_i       <= rq.alpha;
    shape_addr_i     <= rq.addr;
    shape_word_i     <= rq.word;
    do @(posedge clk_i); while (in_stall_o);
    if (rq.act == ActShape) begin
      shape_mem[rq.addr]     = rq.word;
      shape_written[rq.addr] = 1'b1;
    end else begin
      res = composite_pixel(rq);
      pending_pixels.push_back(typed ? typed_res : res);
    end
  endtask

  // Drop valid, drain all results, let the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    apply_reg(idx, val);
  endtask

  // Close a register group and load every store entry the window can read
  task automatic end_config();
    int w_eff, h_eff;
    cfg_we_i <= 1'b0;
    w_eff = (int'(cur_w) > CurW) ? CurW : int'(cur_w);
    h_eff = (int'(cur_h) > CurH) ? CurH : int'(cur_h);
    if (cur_vis) begin
      for (int dy = 0; dy < h_eff; dy++) begin
        for (int dx = 0; dx < w_eff; dx++) begin
          if (!shape_written[dy * CurW + dx])
            push_request(shape_req(12'(dy * CurW + dx), rand_word()), 1'b0, '0);
        end
      end
    end
  endtask

  // One random setting of all registers, then a burst of mixed requests
  task automatic run_phase(input int count);
    int          lv, tv, wv, hv, span;
    logic [12:0] fwv;
    wait_idle();
    case ($urandom_range(0, 9))
      0: fwv = '0;
      1: fwv = 13'd4096;
      2: fwv = 13'h1FFF;
      3: fwv = 13'($urandom);
      default: fwv = 13'($urandom_range(1, 40));
    endcase
    span = (fwv == '0) ? 1 : ((fwv > 13'd64) ? 64 : int'(fwv));
    lv = $urandom_range(0, span) - $urandom_range(0, 8);
    tv = $urandom_range(0, 6) - $urandom_range(0, 4);
    case ($urandom_range(0, 9))
      0: lv = -4096;
      1: lv = 4095;
      2: tv = -4096;
      3: tv = 4095;
      4: lv = $urandom_range(0, 8191) - 4096;
      default: ;
    endcase
    // Keep one side of a full-size window narrow
    case ($urandom_range(0, 5))
      0: begin wv = $urandom_range(64, 127); hv = $urandom_range(0, 3); end
      1: begin wv = $urandom_range(0, 3); hv = $urandom_range(64, 127); end
      default: begin wv = $urandom_range(0, 12); hv = $urandom_range(0, 12); end
    endcase
    write_reg(RegFrameWidth, fwv);
    write_reg(RegCursorLeft, 13'(lv));
    write_reg(RegCursorTop, 13'(tv));
    write_reg(RegCursorWidth, {6'($urandom), 7'(wv)});
    write_reg(RegCursorHeight, {6'($urandom), 7'(hv)});
    write_reg(RegCursorMode, {12'($urandom), 1'($urandom)});
    write_reg(RegCursorVisible, {12'($urandom), 1'($urandom_range(0, 4) != 0)});
    end_config();
    quiet = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 12)
        push_request(shape_req(12'($urandom), rand_word()), 1'b0, '0);
      else
        push_request(pixel_req(1'(k == 0 || $urandom_range(0, 49) == 0), rand_chan(),
                               rand_chan(), rand_chan(), rand_chan()), 1'b0, '0);
    end
  endtask

  // Run with start of frame on the first pixel only, across several row ends and a cursor band
  task automatic run_long_line(input logic [12:0] fwv, input int lv, input int tv,
                               input int wv, input int hv);
    wait_idle();
    write_reg(RegFrameWidth, fwv);
    write_reg(RegCursorLeft, 13'(lv));
    write_reg(RegCursorTop, 13'(tv));
    write_reg(RegCursorWidth, 13'(wv));
    write_reg(RegCursorHeight, 13'(hv));
    write_reg(RegCursorMode, {12'b0, 1'($urandom)});
    write_reg(RegCursorVisible, 13'd1);
    end_config();
    quiet = 1'b1;
    for (int k = 0; k < LongLine; k++)
      push_request(pixel_req(1'(k == 0), rand_chan(), rand_chan(), rand_chan(), rand_chan()),
                   1'b0, '0);
  endtask

  // Receiver stall: runs of random length, stalled or free
  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 2) == 0);
      stall_run   <= pick_gap();
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want, got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each taken result with the oldest predicted pixel
  always @(posedge clk_i) begin : check_result
    out_pix_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {out_blue_o, out_green_o, out_red_o, out_alpha_o, under_cursor_o};
      if (pending_pixels.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("out_blue", want.blue, got.blue);
        check_field("out_green", want.green, got.green);
        check_field("out_red", want.red, got.red);
        check_field("out_alpha", want.alpha, got.alpha);
        check_field("under_cursor", 8'(want.under), 8'(got.under));
      end
    end
  end

  // Hang detection: cycles with no transfer anywhere
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= HangLimit);
    $display("** cursor_overlay_compositor_top: FAILED **");
    $finish;
  end

  initial begin
    bit cfg_open;
    int rand_items;
    cfg_open   = 1'b0;
    rand_items = 0;

    // Directed table: pass-through after reset, store loads, blend and XOR,
    // window edges, register extremes and size saturation, hidden cursor
    plan.push_back(pix_typed(1'b1, 8'h00, 8'hFF, 8'h00, 8'hFF,
                             8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0));
    plan.push_back(pix_typed(1'b0, 8'hFF, 8'h00, 8'hFF, 8'h00,
                             8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0));
    plan.push_back(shape_row(12'd0, 32'hFFFF_FFFF));
    plan.push_back(shape_row(12'd1, 32'h0000_0000));
    plan.push_back(shape_row(12'd64, 32'h8010_2030));
    plan.push_back(shape_row(12'd65, 32'h7F40_C0FF));
    plan.push_back(shape_row(12'd4095, 32'hFFFF_FFFF));
    plan.push_back(reg_row(RegCursorLeft, 13'd0));
    plan.push_back(reg_row(RegCursorTop, 13'd0));
    plan.push_back(reg_row(RegCursorWidth, 13'd2));
    plan.push_back(reg_row(RegCursorHeight, 13'd2));
    plan.push_back(reg_row(RegCursorMode, {12'b0, ModeAlpha}));
    plan.push_back(reg_row(RegCursorVisible, 13'd1));
    plan.push_back(reg_row(RegFrameWidth, 13'd2));
    // opaque cursor replaces, transparent cursor keeps the frame
    plan.push_back(pix_typed(1'b1, 8'h00, 8'h00, 8'h00, 8'h00,
                             8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    plan.push_back(pix_typed(1'b0, 8'h5A, 8'hA5, 8'h3C, 8'h10,
                             8'h5A, 8'hA5, 8'h3C, 8'hFF, 1'b1));
    plan.push_back(pix_row(1'b0, 8'h12, 8'h34, 8'h56, 8'h78));
    plan.push_back(pix_row(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    plan.push_back(pix_typed(1'b0, 8'h9A, 8'hBC, 8'hDE, 8'hF0,
                             8'h9A, 8'hBC, 8'hDE, 8'hF0, 1'b0));
    plan.push_back(reg_row(RegCursorMode, {12'b0, ModeXor}));
    plan.push_back(pix_typed(1'b1, 8'h0F, 8'hF0, 8'h55, 8'h00,
                             8'hF0, 8'h0F, 8'hAA, 8'hFF, 1'b1));
    plan.push_back(pix_typed(1'b0, 8'h11, 8'h22, 8'h33, 8'h44,
                             8'h11, 8'h22, 8'h33, 8'hFF, 1'b1));
    // window far off either side
    plan.push_back(reg_row(RegCursorLeft, 13'h1000));
    plan.push_back(reg_row(RegCursorTop, 13'h1000));
    plan.push_back(pix_typed(1'b1, 8'h01, 8'h02, 8'h03, 8'h04,
                             8'h01, 8'h02, 8'h03, 8'h04, 1'b0));
    plan.push_back(reg_row(RegCursorLeft, 13'h0FFF));
    plan.push_back(reg_row(RegCursorTop, 13'h0FFF));
    plan.push_back(reg_row(RegFrameWidth, 13'h1FFF));
    plan.push_back(pix_typed(1'b1, 8'hFF, 8'h80, 8'h7F, 8'h01,
                             8'hFF, 8'h80, 8'h7F, 8'h01, 1'b0));
    // width saturates to the store width
    plan.push_back(reg_row(RegCursorMode, {12'b0, ModeAlpha}));
    plan.push_back(reg_row(RegCursorLeft, 13'(-62)));
    plan.push_back(reg_row(RegCursorTop, 13'd0));
    plan.push_back(reg_row(RegCursorWidth, 13'd127));
    plan.push_back(reg_row(RegCursorHeight, 13'd1));
    plan.push_back(pix_row(1'b1, 8'h20, 8'h40, 8'h60, 8'h80));
    plan.push_back(pix_row(1'b0, 8'hA0, 8'hC0, 8'hE0, 8'hFF));
    plan.push_back(pix_typed(1'b0, 8'h33, 8'h66, 8'h99, 8'hCC,
                             8'h33, 8'h66, 8'h99, 8'hCC, 1'b0));
    // height saturates, zero frame width acts as one
    plan.push_back(reg_row(RegCursorLeft, 13'd0));
    plan.push_back(reg_row(RegCursorTop, 13'(-63)));
    plan.push_back(reg_row(RegCursorWidth, 13'd1));
    plan.push_back(reg_row(RegCursorHeight, 13'd127));
    plan.push_back(reg_row(RegFrameWidth, 13'd0));
    plan.push_back(pix_row(1'b1, 8'h55, 8'hAA, 8'h55, 8'hAA));
    plan.push_back(pix_typed(1'b0, 8'h44, 8'h55, 8'h66, 8'h77,
                             8'h44, 8'h55, 8'h66, 8'h77, 1'b0));
    // hidden cursor passes everything through
    plan.push_back(reg_row(RegCursorVisible, 13'd0));
    plan.push_back(pix_typed(1'b1, 8'hC3, 8'h3C, 8'h81, 8'h7E,
                             8'hC3, 8'h3C, 8'h81, 8'h7E, 1'b0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the table
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!cfg_open) begin
          wait_idle();
          cfg_open = 1'b1;
        end
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        if (cfg_open) begin
          end_config();
          cfg_open = 1'b0;
        end
        push_request(plan[i].rq, plan[i].typed, plan[i].res);
      end
    end

    // Random part
    while (rand_items < RandItems) begin
      int n;
      n = $urandom_range(20, 80);
      run_phase(n);
      rand_items += n;
    end
    run_long_line(13'd1, 0, 40, 1, 16);
    run_long_line(13'd24, 16, 0, 16, 2);

    wait_idle();
    if (mismatch_count == 0 && pending_pixels.size() == 0)
      $display("** cursor_overlay_compositor_top: PASSED **");
    else
      $display("** cursor_overlay_compositor_top: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
hdl/coc_pkg.sv
hdl/coc_ram.sv
hdl/coc_fifo.sv
hdl/cursor_overlay_compositor_top.sv
hdl/coc_checker.sv
verif/cursor_overlay_compositor_top_tb.sv
